// ===== rtl/core/fdr_pkg.sv =====
// Shared widths, register codes and cell payload types for the Fresnel
// dielectric reflectance pipeline. No dependencies.
package fdr_pkg;

   localparam int ETA_W      = 16;
   localparam int COS_W      = 16;
   localparam int REFL_W     = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CM_W       = 15;   // clamped cosine magnitude, 0..16384
   localparam int CC_W       = 29;   // cos^2 in Q28, up to 2^28
   localparam int SQR_W      = 32;   // square of a Q4.12 index
   localparam int PROD_W     = 61;   // SQR_W x CC_W product
   localparam int LHS_W      = 60;
   localparam int EEC_W      = 46;
   localparam int IC_W       = 30;
   localparam int ROOT_W     = 30;
   localparam int REM_W      = 31;
   localparam int RAD_W      = 60;
   localparam int SQRT_STEPS = 30;
   localparam int DEN_W      = 47;
   localparam int QUO_W      = 17;
   localparam int DIV_STEPS  = 17;
   localparam int DVD_W      = 64;
   localparam int SQ_W       = 34;
   localparam int SUM_W      = 35;
   localparam int SUM_SHIFT  = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_ETA_INCIDENT    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ETA_TRANSMITTED = 8'd1;

   localparam logic [ETA_W-1:0]        ETA_RESET     = 16'd4096;
   localparam logic signed [COS_W-1:0] COS_ONE       = 16'sd16384;
   localparam logic signed [COS_W-1:0] COS_MINUS_ONE = -16'sd16384;
   localparam logic [CC_W-1:0]         SIN2_ONE      = 29'd268435456;
   localparam logic [REFL_W-1:0]       REFL_ONE      = 16'd32768;
   localparam logic [QUO_W-1:0]        RATIO_ONE     = 17'd65536;
   localparam logic [SUM_W-1:0]        SUM_ROUND     = 35'd131072;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sqrt_lane_type;

   typedef struct packed {
      logic              tir;
      logic [EEC_W-1:0]  eec;
      logic [IC_W-1:0]   ic;
      logic [ETA_W-1:0]  ei;
   } sqrt_side_type;

   typedef struct packed {
      logic [DEN_W-1:0] p;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] bits;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic       tir;
      logic [1:0] zden;
   } div_side_type;

endpackage

// ===== rtl/core/fdr_sqrt_cell.sv =====
// One step of the pipelined integer square root: settles one root bit.
// Depends on fdr_pkg.
module fdr_sqrt_cell
   import fdr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          prev_valid,
   input  sqrt_lane_type prev_lane,
   input  sqrt_side_type prev_side,
   output logic          cell_valid,
   output sqrt_lane_type cell_lane,
   output sqrt_side_type cell_side
);

   logic          valid_ff;
   sqrt_lane_type lane_ff;
   sqrt_lane_type lane_in;
   sqrt_side_type side_ff;
   logic [REM_W+1:0] rem2;
   logic [REM_W+1:0] trial;

   always_comb begin
      rem2  = {prev_lane.rem, prev_lane.rad[RAD_W-1 -: 2]};
      trial = {1'b0, prev_lane.root, 2'b01};
      lane_in.rad = {prev_lane.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         lane_in.rem  = REM_W'(rem2 - trial);
         lane_in.root = {prev_lane.root[ROOT_W-2:0], 1'b1};
      end else begin
         lane_in.rem  = rem2[REM_W-1:0];
         lane_in.root = {prev_lane.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         side_ff <= prev_side;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_lane  = lane_ff;
   assign cell_side  = side_ff;

endmodule

// ===== rtl/core/fdr_div_cell.sv =====
// One step of the two-lane restoring divider: settles one quotient bit per lane.
// Depends on fdr_pkg.
module fdr_div_cell
   import fdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         prev_valid,
   input  div_lane_type prev_lane [2],
   input  div_side_type prev_side,
   output logic         cell_valid,
   output div_lane_type cell_lane [2],
   output div_side_type cell_side
);

   logic         valid_ff;
   div_lane_type lane_ff [2];
   div_lane_type lane_in [2];
   div_side_type side_ff;
   logic [DEN_W:0] p2  [2];
   logic [DEN_W:0] dd  [2];
   logic [1:0]     ge;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         p2[k] = {prev_lane[k].p, prev_lane[k].bits[QUO_W-1]};
         dd[k] = {1'b0, prev_lane[k].den};
         ge[k] = (p2[k] >= dd[k]);
         lane_in[k].den  = prev_lane[k].den;
         lane_in[k].bits = {prev_lane[k].bits[QUO_W-2:0], 1'b0};
         lane_in[k].quo  = {prev_lane[k].quo[QUO_W-2:0], ge[k]};
         if (ge[k]) begin
            lane_in[k].p = DEN_W'(p2[k] - dd[k]);
         end else begin
            lane_in[k].p = p2[k][DEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         side_ff <= prev_side;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_lane  = lane_ff;
   assign cell_side  = side_ff;

endmodule

// ===== rtl/core/fresnel_dielectric_reflectance.sv =====
// Top level of the Fresnel dielectric reflectance pipeline.
// Depends on fdr_pkg, fdr_sqrt_cell and fdr_div_cell.
//
// Takes one signed Q2.14 incident cosine per beat and returns the unpolarized
// reflectance in Q1.15 plus a total-internal-reflection flag. The block is a
// fixed pipeline of 56 stages: four front stages (clamp and index swap, squares,
// products, exact TIR compare), a row of 30 square-root cells that each settle
// one root bit, three stages that form the ratio numerators and denominators,
// a row of 17 two-lane divider cells that each settle one quotient bit, one
// squaring stage and the output register. A new cosine is taken every cycle;
// unless the pipeline holds. A two-entry output buffer decouples the result side,
// so the pipeline only holds once both entries are full. The index registers
// are written through the csr_ port (always ready) and must only change while
// no beat is in flight.
module fresnel_dielectric_reflectance
   import fdr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [COS_W-1:0]     req_tdata,   // [15:0] cos_incident
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [REFL_W-1:0]    rsp_tdata,   // [15:0] reflectance
   output logic                 rsp_tuser,   // [0] total_internal
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ETA_W-1:0]     csr_data
);

   // ---------------- index registers
   logic [ETA_W-1:0] eta_i_ff, eta_t_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_i_ff <= ETA_RESET;
         eta_t_ff <= ETA_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_ETA_INCIDENT) begin
            eta_i_ff <= csr_data;
         end
         if (csr_index == CSR_ETA_TRANSMITTED) begin
            eta_t_ff <= csr_data;
         end
      end
   end

   // Whole pipeline advances together; it holds only when the skid entry is full.
   logic en;

   // ---------------- stage 0: clamp, swap indices when not entering
   logic signed [COS_W-1:0] cos_raw, cos_cl;
   logic                    leaving;
   logic [COS_W-1:0]        cos_mag;
   logic                    s0_valid_ff;
   logic [CM_W-1:0]         s0_cm_ff, s0_cm_in;
   logic [ETA_W-1:0]        s0_ei_ff, s0_ei_in, s0_et_ff, s0_et_in;

   always_comb begin
      cos_raw = req_tdata;
      cos_cl  = cos_raw;
      if (cos_raw > COS_ONE) begin
         cos_cl = COS_ONE;
      end else if (cos_raw < COS_MINUS_ONE) begin
         cos_cl = COS_MINUS_ONE;
      end
      leaving = (cos_cl <= 0);
      cos_mag = leaving ? COS_W'(-cos_cl) : COS_W'(cos_cl);
      s0_cm_in = cos_mag[CM_W-1:0];
      s0_ei_in = leaving ? eta_t_ff : eta_i_ff;
      s0_et_in = leaving ? eta_i_ff : eta_t_ff;
   end

   // ---------------- stage 1: squares
   logic             s1_valid_ff;
   logic [CM_W-1:0]  s1_cm_ff;
   logic [ETA_W-1:0] s1_ei_ff;
   logic [CC_W-1:0]  s1_cc_ff, s1_cc_in;
   logic [SQR_W-1:0] s1_ii_ff, s1_ii_in, s1_ee_ff, s1_ee_in;
   logic [2*CM_W-1:0] cc_full;

   always_comb begin
      cc_full  = (2*CM_W)'(s0_cm_ff) * (2*CM_W)'(s0_cm_ff);
      s1_cc_in = cc_full[CC_W-1:0];
      s1_ii_in = SQR_W'(s0_ei_ff) * SQR_W'(s0_ei_ff);
      s1_ee_in = SQR_W'(s0_et_ff) * SQR_W'(s0_et_ff);
   end

   // ---------------- stage 2: I^2*sin^2, E^2*C, I*C
   logic              s2_valid_ff;
   logic [LHS_W-1:0]  s2_lhs_ff, s2_lhs_in;
   logic [SQR_W-1:0]  s2_ee_ff;
   logic [EEC_W-1:0]  s2_eec_ff, s2_eec_in;
   logic [IC_W-1:0]   s2_ic_ff, s2_ic_in;
   logic [ETA_W-1:0]  s2_ei_ff;
   logic [CC_W-1:0]   sin2;
   logic [PROD_W-1:0] lhs_full;
   logic [SQR_W+CM_W-1:0]  eec_full;
   logic [ETA_W+CM_W-1:0]  ic_full;

   always_comb begin
      sin2      = SIN2_ONE - s1_cc_ff;
      lhs_full  = PROD_W'(s1_ii_ff) * PROD_W'(sin2);
      eec_full  = (SQR_W+CM_W)'(s1_ee_ff) * (SQR_W+CM_W)'(s1_cm_ff);
      ic_full   = (ETA_W+CM_W)'(s1_ei_ff) * (ETA_W+CM_W)'(s1_cm_ff);
      s2_lhs_in = lhs_full[LHS_W-1:0];
      s2_eec_in = eec_full[EEC_W-1:0];
      s2_ic_in  = ic_full[IC_W-1:0];
   end

   // ---------------- stage 3: exact TIR compare and radicand
   logic             s3_valid_ff;
   logic             s3_tir_ff, s3_tir_in;
   logic [RAD_W-1:0] s3_d_ff, s3_d_in;
   logic [EEC_W-1:0] s3_eec_ff;
   logic [IC_W-1:0]  s3_ic_ff;
   logic [ETA_W-1:0] s3_ei_ff;
   logic [LHS_W-1:0] rhs;

   always_comb begin
      rhs       = {s2_ee_ff, 28'd0};
      s3_tir_in = (s2_lhs_ff >= rhs);
      s3_d_in   = s3_tir_in ? '0 : (rhs - s2_lhs_ff);
   end

   // ---------------- square-root cell row
   logic          sq_valid [SQRT_STEPS+1];
   sqrt_lane_type sq_lane  [SQRT_STEPS+1];
   sqrt_side_type sq_side  [SQRT_STEPS+1];

   always_comb begin
      sq_valid[0]     = s3_valid_ff;
      sq_lane[0].rem  = '0;
      sq_lane[0].root = '0;
      sq_lane[0].rad  = s3_d_ff;
      sq_side[0].tir  = s3_tir_ff;
      sq_side[0].eec  = s3_eec_ff;
      sq_side[0].ic   = s3_ic_ff;
      sq_side[0].ei   = s3_ei_ff;
   end

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      fdr_sqrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .prev_valid (sq_valid[g]),
         .prev_lane  (sq_lane[g]),
         .prev_side  (sq_side[g]),
         .cell_valid (sq_valid[g+1]),
         .cell_lane  (sq_lane[g+1]),
         .cell_side  (sq_side[g+1])
      );
   end

   // ---------------- stage M: I*Q
   logic              sm_valid_ff;
   logic              sm_tir_ff;
   logic [EEC_W-1:0]  sm_eec_ff;
   logic [IC_W-1:0]   sm_ic_ff;
   logic [ROOT_W-1:0] sm_q_ff;
   logic [EEC_W-1:0]  sm_iq_ff, sm_iq_in;

   assign sm_iq_in = EEC_W'(sq_side[SQRT_STEPS].ei) * EEC_W'(sq_lane[SQRT_STEPS].root);

   // ---------------- stage N: numerators and denominators
   logic             sn_valid_ff;
   logic             sn_tir_ff;
   logic [DEN_W-1:0] sn_num_ff [2];
   logic [DEN_W-1:0] sn_den_ff [2];
   logic [DEN_W-1:0] sn_num_in [2];
   logic [DEN_W-1:0] sn_den_in [2];
   logic [DEN_W-1:0] ra [2];
   logic [DEN_W-1:0] rb [2];

   always_comb begin
      ra[0] = DEN_W'(sm_eec_ff);
      rb[0] = DEN_W'(sm_iq_ff);
      ra[1] = DEN_W'(sm_ic_ff);
      rb[1] = DEN_W'(sm_q_ff);
      for (int k = 0; k < 2; k++) begin
         sn_den_in[k] = ra[k] + rb[k];
         sn_num_in[k] = (ra[k] > rb[k]) ? (ra[k] - rb[k]) : (rb[k] - ra[k]);
      end
   end

   // ---------------- stage D: rounded dividend, split for the divider row
   logic         sd_valid_ff;
   div_lane_type sd_lane_ff [2];
   div_lane_type sd_lane_in [2];
   div_side_type sd_side_ff, sd_side_in;
   logic [DVD_W-1:0] dvd [2];

   always_comb begin
      sd_side_in.tir = sn_tir_ff;
      for (int k = 0; k < 2; k++) begin
         dvd[k] = {1'b0, sn_num_ff[k], 16'd0} + DVD_W'(sn_den_ff[k] >> 1);
         sd_lane_in[k].p    = dvd[k][DVD_W-1:QUO_W];
         sd_lane_in[k].bits = dvd[k][QUO_W-1:0];
         sd_lane_in[k].den  = sn_den_ff[k];
         sd_lane_in[k].quo  = '0;
         sd_side_in.zden[k] = (sn_den_ff[k] == '0);
      end
   end

   // ---------------- divider cell row
   logic         dv_valid [DIV_STEPS+1];
   div_lane_type dv_lane  [DIV_STEPS+1][2];
   div_side_type dv_side  [DIV_STEPS+1];

   assign dv_valid[0] = sd_valid_ff;
   assign dv_lane[0]  = sd_lane_ff;
   assign dv_side[0]  = sd_side_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      fdr_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .prev_valid (dv_valid[g]),
         .prev_lane  (dv_lane[g]),
         .prev_side  (dv_side[g]),
         .cell_valid (dv_valid[g+1]),
         .cell_lane  (dv_lane[g+1]),
         .cell_side  (dv_side[g+1])
      );
   end

   // ---------------- stage F: square the two ratios
   logic            sf_valid_ff;
   logic            sf_tir_ff;
   logic [SQ_W-1:0] sf_sq_ff [2];
   logic [SQ_W-1:0] sf_sq_in [2];
   logic [QUO_W-1:0] ratio [2];

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         // a zero denominator only shows up at a grazing cosine or under TIR: ratio is one
         ratio[k]    = dv_side[DIV_STEPS].zden[k] ? RATIO_ONE : dv_lane[DIV_STEPS][k].quo;
         sf_sq_in[k] = SQ_W'(ratio[k]) * SQ_W'(ratio[k]);
      end
   end

   // ---------------- final average and saturation
   logic               fin_valid;
   logic [REFL_W-1:0]  fin_refl;
   logic               fin_tir;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-SUM_SHIFT-1:0] avg;

   always_comb begin
      sum       = SUM_W'(sf_sq_ff[0]) + SUM_W'(sf_sq_ff[1]) + SUM_ROUND;
      avg       = sum[SUM_W-1:SUM_SHIFT];
      fin_valid = sf_valid_ff;
      fin_tir   = sf_tir_ff;
      if (sf_tir_ff || (avg > (SUM_W-SUM_SHIFT)'(REFL_ONE))) begin
         fin_refl = REFL_ONE;
      end else begin
         fin_refl = avg[REFL_W-1:0];
      end
   end

   // ---------------- pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         sm_valid_ff <= 1'b0;
         sn_valid_ff <= 1'b0;
         sd_valid_ff <= 1'b0;
         sf_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         sm_valid_ff <= sq_valid[SQRT_STEPS];
         sn_valid_ff <= sm_valid_ff;
         sd_valid_ff <= sn_valid_ff;
         sf_valid_ff <= dv_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_cm_ff   <= s0_cm_in;
         s0_ei_ff   <= s0_ei_in;
         s0_et_ff   <= s0_et_in;
         s1_cm_ff   <= s0_cm_ff;
         s1_ei_ff   <= s0_ei_ff;
         s1_cc_ff   <= s1_cc_in;
         s1_ii_ff   <= s1_ii_in;
         s1_ee_ff   <= s1_ee_in;
         s2_lhs_ff  <= s2_lhs_in;
         s2_ee_ff   <= s1_ee_ff;
         s2_eec_ff  <= s2_eec_in;
         s2_ic_ff   <= s2_ic_in;
         s2_ei_ff   <= s1_ei_ff;
         s3_tir_ff  <= s3_tir_in;
         s3_d_ff    <= s3_d_in;
         s3_eec_ff  <= s2_eec_ff;
         s3_ic_ff   <= s2_ic_ff;
         s3_ei_ff   <= s2_ei_ff;
         sm_tir_ff  <= sq_side[SQRT_STEPS].tir;
         sm_eec_ff  <= sq_side[SQRT_STEPS].eec;
         sm_ic_ff   <= sq_side[SQRT_STEPS].ic;
         sm_q_ff    <= sq_lane[SQRT_STEPS].root;
         sm_iq_ff   <= sm_iq_in;
         sn_tir_ff  <= sm_tir_ff;
         sn_num_ff  <= sn_num_in;
         sn_den_ff  <= sn_den_in;
         sd_lane_ff <= sd_lane_in;
         sd_side_ff <= sd_side_in;
         sf_tir_ff  <= dv_side[DIV_STEPS].tir;
         sf_sq_ff   <= sf_sq_in;
      end
   end

   // ---------------- output register plus skid entry
   logic              out_valid_ff, out_valid_in;
   logic [REFL_W-1:0] out_refl_ff, out_refl_in;
   logic              out_tir_ff, out_tir_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [REFL_W-1:0] skid_refl_ff, skid_refl_in;
   logic              skid_tir_ff, skid_tir_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_refl_in   = out_refl_ff;
      out_tir_in    = out_tir_ff;
      skid_valid_in = skid_valid_ff;
      skid_refl_in  = skid_refl_ff;
      skid_tir_in   = skid_tir_ff;
      if (en) begin
         if (out_valid_ff && !rsp_tready) begin
            // output beat stalled: park the arriving result
            skid_valid_in = fin_valid;
            skid_refl_in  = fin_refl;
            skid_tir_in   = fin_tir;
         end else begin
            out_valid_in = fin_valid;
            out_refl_in  = fin_refl;
            out_tir_in   = fin_tir;
         end
      end else if (rsp_tready) begin
         // drain the parked result into the output register
         out_valid_in  = 1'b1;
         out_refl_in   = skid_refl_ff;
         out_tir_in    = skid_tir_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_refl_ff  <= out_refl_in;
      out_tir_ff   <= out_tir_in;
      skid_refl_ff <= skid_refl_in;
      skid_tir_ff  <= skid_tir_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_refl_ff;
   assign rsp_tuser  = out_tir_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for fresnel_dielectric_reflectance: drives cosines on the
// req_ stream and checks each rsp_ beat against an in-bench reflectance predictor.
// Depends on fdr_pkg and the block's RTL only.
module testbench;
   import fdr_pkg::*;

   typedef struct {
      logic [REFL_W-1:0] refl;
      logic              tir;
   } refl_item_type;

   // One row of the directed table: either a cosine or a pair of index writes.
   typedef struct {
      logic               is_cfg;
      logic [ETA_W-1:0]   ei;
      logic [ETA_W-1:0]   et;
      logic [COS_W-1:0]   cosv;
      logic               known;     // expected value typed in
      logic [REFL_W-1:0]  refl;
      logic               tir;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [COS_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [REFL_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ETA_W-1:0]     csr_data;

   logic [ETA_W-1:0] eta_in_q;   // predictor's copy of the index registers
   logic [ETA_W-1:0] eta_tr_q;
   refl_item_type    pending_refl[$];
   int               mismatches;
   bit               drain_done;
   bit               rsp_no_stall;

   fresnel_dielectric_reflectance u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Magnitude of (a-b)/(a+b) in Q16, rounded half up; empty denominator reads 1.0.
   function automatic logic [63:0] amp_ratio(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] num;
      logic [63:0] den;
      num = (a > b) ? a - b : b - a;
      den = a + b;
      if (den == 0) return 64'd65536;
      return ((num << 16) + (den >> 1)) / den;
   endfunction

   function automatic refl_item_type predict_reflectance(input logic [COS_W-1:0] raw);
      refl_item_type r;
      int          c;
      logic [63:0] ei, et, cm, s2, lhs, rhs, q, r1, r2, sum, tmp;
      c = int'($signed(raw));
      ei = 64'(eta_in_q);
      et = 64'(eta_tr_q);
      if (c > 16384) c = 16384;
      if (c < -16384) c = -16384;
      // zero or negative cosine: ray leaves the medium, swap the indices
      if (c <= 0) begin
         tmp = ei;
         ei = et;
         et = tmp;
         c = -c;
      end
      cm = 64'(c);
      s2 = (64'd1 << 28) - cm * cm;
      lhs = ei * ei * s2;
      rhs = (et * et) << 28;
      if (lhs >= rhs) begin
         r.refl = REFL_ONE;
         r.tir = 1'b1;
         return r;
      end
      q = isqrt64(rhs - lhs);
      r1 = amp_ratio(et * et * cm, ei * q);
      r2 = amp_ratio(ei * cm, q);
      sum = (r1 * r1 + r2 * r2 + (64'd1 << 17)) >> 18;
      if (sum > 64'd32768) sum = 64'd32768;
      r.refl = sum[REFL_W-1:0];
      r.tir = 1'b0;
      return r;
   endfunction

   task automatic write_index(input logic [CSR_IDX_W-1:0] idx, input logic [ETA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ETA_INCIDENT) eta_in_q = val;
      else if (idx == CSR_ETA_TRANSMITTED) eta_tr_q = val;
   endtask

   // Wait for every expected beat, then let the pipe empty before touching the indices.
   task automatic wait_idle();
      while (pending_refl.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic set_indices(input logic [ETA_W-1:0] ei, input logic [ETA_W-1:0] et);
      wait_idle();
      write_index(CSR_ETA_INCIDENT, ei);
      write_index(CSR_ETA_TRANSMITTED, et);
      // an out-of-range index must be dropped by the block
      write_index(CSR_IDX_W'(2 + $urandom_range(0, 250)), ETA_W'($urandom));
   endtask

   // Hold one cosine until accepted; gaps optional so busy phases see bubbles too.
   task automatic send_cosine(input logic [COS_W-1:0] cosv, input bit gaps);
      if (gaps) begin
         while ($urandom_range(0, 99) < 33) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cosv;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_refl.push_back(predict_reflectance(cosv));
   endtask

   function automatic logic [COS_W-1:0] random_cosine();
      case ($urandom_range(0, 9))
         0: return COS_W'($urandom);                        // full raw range
         1: return COS_W'($urandom_range(16384, 32767));     // clamped high
         2: return COS_W'(-$urandom_range(16384, 32768));    // clamped low
         3: return COS_W'($urandom_range(0, 64));            // grazing
         4: return COS_W'(-$urandom_range(0, 64));
         default: return COS_W'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [ETA_W-1:0] random_eta();
      case ($urandom_range(0, 5))
         0: return ETA_W'($urandom);
         1: return ETA_W'($urandom_range(1, 16));
         2: return 16'hFFFF;
         default: return ETA_W'($urandom_range(3500, 12000));  // glass, water, gems
      endcase
   endfunction

   // Result side: random stalls except during a long clean stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= rsp_no_stall || ($urandom_range(0, 99) >= 33);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_refl.size() == 0) begin
               $display("%0t: unexpected beat refl=%0d tir=%0b", $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               refl_item_type e;
               e = pending_refl.pop_front();
               if (rsp_tdata !== e.refl) begin
                  $display("%0t: reflectance expected %0d actual %0d", $time, e.refl,
                           rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== e.tir) begin
                  $display("%0t: total_internal expected %0b actual %0b", $time, e.tir,
                           rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
   end

   // Directed rows: typed expectations only where they are obvious.
   dir_row_type dir_rows[] = '{
      '{1'b0, 16'd0, 16'd0, 16'h4000, 1'b1, 16'd0, 1'b0},      // reset indices, normal
      '{1'b0, 16'd0, 16'd0, 16'h7FFF, 1'b1, 16'd0, 1'b0},      // clamped high
      '{1'b0, 16'd0, 16'd0, 16'h8000, 1'b1, 16'd0, 1'b0},      // clamped low
      '{1'b0, 16'd0, 16'd0, 16'h0000, 1'b0, 16'd0, 1'b0},      // zero cosine
      '{1'b0, 16'd0, 16'd0, 16'h0001, 1'b0, 16'd0, 1'b0},
      '{1'b1, 16'd4096, 16'd6144, 16'd0, 1'b0, 16'd0, 1'b0},  // air to glass
      '{1'b0, 16'd0, 16'd0, 16'h2000, 1'b0, 16'd0, 1'b0},
      '{1'b0, 16'd0, 16'd0, 16'hE000, 1'b0, 16'd0, 1'b0},      // exiting glass
      '{1'b0, 16'd0, 16'd0, 16'hFFFF, 1'b1, REFL_ONE, 1'b1},   // grazing exit: TIR
      '{1'b1, 16'd4096, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0},     // transmitted index zero
      '{1'b0, 16'd0, 16'd0, 16'h4000, 1'b1, REFL_ONE, 1'b1},
      '{1'b0, 16'd0, 16'd0, 16'h1234, 1'b1, REFL_ONE, 1'b1},
      '{1'b1, 16'd0, 16'd4096, 16'd0, 1'b0, 16'd0, 1'b0},     // incident index zero
      '{1'b0, 16'd0, 16'd0, 16'h4000, 1'b0, 16'd0, 1'b0},
      '{1'b0, 16'd0, 16'd0, 16'h0000, 1'b1, REFL_ONE, 1'b1},   // swap puts zero on far side
      '{1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 16'd0, 1'b0},  // extremes
      '{1'b0, 16'd0, 16'd0, 16'h4000, 1'b1, 16'd0, 1'b0},
      '{1'b0, 16'd0, 16'd0, 16'h5555, 1'b0, 16'd0, 1'b0},
      '{1'b1, 16'd1, 16'hFFFF, 16'd0, 1'b0, 16'd0, 1'b0},
      '{1'b0, 16'd0, 16'd0, 16'h0002, 1'b0, 16'd0, 1'b0},
      '{1'b0, 16'd0, 16'd0, 16'hAAAA, 1'b0, 16'd0, 1'b0}
   };

   initial begin
      int n;
      mismatches   = 0;
      drain_done   = 1'b0;
      rsp_no_stall = 1'b0;
      eta_in_q     = ETA_RESET;
      eta_tr_q     = ETA_RESET;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            req_tvalid <= 1'b0;
            set_indices(dir_rows[i].ei, dir_rows[i].et);
         end else begin
            send_cosine(dir_rows[i].cosv, 1'b1);
            if (dir_rows[i].known) begin
               refl_item_type p;
               p = pending_refl[$];
               // hold the typed value against the predictor's own
               if (p.refl !== dir_rows[i].refl || p.tir !== dir_rows[i].tir) begin
                  $display("%0t: table row %0d expected %0d/%0b predicted %0d/%0b", $time,
                           i, dir_rows[i].refl, dir_rows[i].tir, p.refl, p.tir);
                  mismatches++;
               end
            end
         end
      end

      // Random phases, each with fresh indices; phase 2 runs without stalls,
      // and each phase ends with the sender pausing until all beats are back.
      for (int ph = 0; ph < 8; ph++) begin
         req_tvalid <= 1'b0;
         if (ph == 7) set_indices(16'hFFFF, 16'd1);
         else if (ph == 6) set_indices(16'd1, 16'hFFFF);
         else set_indices(random_eta(), random_eta());
         rsp_no_stall = (ph == 2);
         n = 80;
         for (int k = 0; k < n; k++) send_cosine(random_cosine(), ph != 2);
      end
      req_tvalid   <= 1'b0;
      rsp_no_stall = 1'b0;
      wait_idle();
      drain_done = 1'b1;
   end

   initial begin
      wait (drain_done);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/fdr_pkg.sv
rtl/core/fdr_sqrt_cell.sv
rtl/core/fdr_div_cell.sv
rtl/core/fresnel_dielectric_reflectance.sv
test/testbench.sv
